/* src/smpp_pkg.sv */
package smpp_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int SCORE_BITS  = 16;
    localparam int COORD_BITS  = 11;
    localparam int GEO_BITS    = 12;
    localparam int BORDER_BITS = 6;
    localparam int CFG_BITS    = 16;
    localparam int LINE_AW     = $clog2(MAX_WIDTH);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [GEO_BITS-1:0]    RST_WIDTH  = GEO_BITS'(640);
    localparam logic [GEO_BITS-1:0]    RST_HEIGHT = GEO_BITS'(480);
    localparam logic [BORDER_BITS-1:0] RST_BORDER = BORDER_BITS'(15);

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BORDER_WIDTH = 2'd2,
        CFG_THRESHOLD    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic [LINE_AW-1:0]           col;
        logic                         test;
        logic [COORD_BITS-1:0]        cx;
        logic [COORD_BITS-1:0]        cy;
        logic                         last;
    } t_item;

endpackage

/* src/score_map_peak_picker_3x3.sv */
// Takes one score word per cycle while the item FIFO has room; results leave through
// the FIFO, the r_s1 and r_s2 stages and the output register, for peaks and frame
// ends only. A pixel is decided by the pixel one row and one column later.
// The line store is one memory port pair: one read and one write per cycle.
// Synchronous active-low reset clears the control state and loads the register
// defaults; line store contents are not cleared.
module score_map_peak_picker_3x3 (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_idx,
    input  logic [smpp_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // score
    input  logic [15:0]                           s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // peak_x, peak_y, peak_score, zero padding
    output logic [39:0]                           m_axis_tdata,
    // frame_end
    output logic                                  m_axis_tlast
);
    import smpp_pkg::*;

    t_item                        push_item;
    t_item                        pop_item;
    logic                         push;
    logic                         pop;
    logic                         empty;
    logic                         full;
    logic signed [SCORE_BITS-1:0] thr;
    logic [COORD_BITS-1:0]        peak_x;
    logic [COORD_BITS-1:0]        peak_y;
    logic signed [SCORE_BITS-1:0] peak_score;

    smpp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_score    (s_axis_tdata[SCORE_BITS-1:0]),
        .i_full     (full),
        .o_push     (push),
        .o_item     (push_item),
        .o_thr      (thr)
    );

    smpp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_empty (empty),
        .o_full  (full)
    );

    smpp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (pop_item),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_thr        (thr),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_peak_x     (peak_x),
        .o_peak_y     (peak_y),
        .o_peak_score (peak_score),
        .o_frame_end  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, peak_score, peak_y, peak_x};

endmodule

/* src/smpp_front.sv */
module smpp_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_idx,
    input  logic [smpp_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [smpp_pkg::SCORE_BITS-1:0] i_score,
    input  logic                                  i_full,
    output logic                                  o_push,
    output smpp_pkg::t_item                       o_item,
    output logic signed [smpp_pkg::SCORE_BITS-1:0] o_thr
);
    import smpp_pkg::*;

    logic [GEO_BITS-1:0]    r_w;
    logic [GEO_BITS-1:0]    r_h;
    logic [BORDER_BITS-1:0] r_b;
    logic signed [SCORE_BITS-1:0] r_thr;
    logic [COORD_BITS-1:0]  r_col;
    logic [COORD_BITS-1:0]  r_row;
    logic [COORD_BITS-1:0]  n_col;
    logic [COORD_BITS-1:0]  n_row;
    logic [GEO_BITS-1:0]    geo_in;
    logic [GEO_BITS-1:0]    geo_clamped;
    logic                   band_here;
    logic                   band_centre;
    logic                   end_of_row;
    logic                   last;
    logic                   accept;

    function automatic logic in_band(
        input logic [COORD_BITS-1:0]  c,
        input logic [COORD_BITS-1:0]  r,
        input logic [GEO_BITS-1:0]    w,
        input logic [GEO_BITS-1:0]    h,
        input logic [BORDER_BITS-1:0] b
    );
        logic [GEO_BITS-1:0] c12;
        logic [GEO_BITS-1:0] r12;
        logic [GEO_BITS-1:0] b12;
        c12 = GEO_BITS'(c);
        r12 = GEO_BITS'(r);
        b12 = GEO_BITS'(b);
        return (c12 < b12) || (c12 + b12 >= w) || (r12 < b12) || (r12 + b12 >= h);
    endfunction

    assign accept  = i_valid && !i_full;
    assign o_ready = !i_full;
    assign o_push  = accept;
    assign o_thr   = r_thr;

    always_comb begin
        geo_in = i_cfg_data[GEO_BITS-1:0];
        if (geo_in < GEO_BITS'(3)) begin
            geo_clamped = GEO_BITS'(3);
        end else if (geo_in > GEO_BITS'(MAX_WIDTH)) begin
            geo_clamped = GEO_BITS'(MAX_WIDTH);
        end else begin
            geo_clamped = geo_in;
        end
    end

    always_comb begin
        band_here   = in_band(r_col, r_row, r_w, r_h, r_b);
        band_centre = in_band(r_col - 1'b1, r_row - 1'b1, r_w, r_h, r_b);
        end_of_row  = (GEO_BITS'(r_col) + 1'b1) >= r_w;
        last        = end_of_row && ((GEO_BITS'(r_row) + 1'b1) >= r_h);
        n_col = r_col + 1'b1;
        n_row = r_row;
        if (end_of_row) begin
            n_col = '0;
            n_row = last ? '0 : r_row + 1'b1;
        end
        o_item.score = band_here ? '0 : i_score;
        o_item.col   = LINE_AW'(r_col);
        o_item.test  = (r_col != '0) && (r_row != '0) && !band_centre;
        o_item.cx    = r_col - 1'b1;
        o_item.cy    = r_row - 1'b1;
        o_item.last  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= RST_WIDTH;
            r_h   <= RST_HEIGHT;
            r_b   <= RST_BORDER;
            r_thr <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH: begin
                    r_w   <= geo_clamped;
                    r_col <= '0;
                    r_row <= '0;
                end
                CFG_FRAME_HEIGHT: begin
                    r_h   <= (geo_clamped > GEO_BITS'(MAX_HEIGHT)) ?
                             GEO_BITS'(MAX_HEIGHT) : geo_clamped;
                    r_col <= '0;
                    r_row <= '0;
                end
                CFG_BORDER_WIDTH: begin
                    r_b <= (i_cfg_data[BORDER_BITS-1:0] == '0) ?
                           BORDER_BITS'(1) : i_cfg_data[BORDER_BITS-1:0];
                end
                CFG_THRESHOLD: begin
                    r_thr <= i_cfg_data[SCORE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

/* src/smpp_fifo.sv */
module smpp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  smpp_pkg::t_item i_item,
    input  logic            i_pop,
    output smpp_pkg::t_item o_item,
    output logic            o_empty,
    output logic            o_full
);
    import smpp_pkg::*;

    t_item                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_AW:0]     r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* src/smpp_back.sv */
module smpp_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  smpp_pkg::t_item                        i_item,
    input  logic                                   i_empty,
    output logic                                   o_pop,
    input  logic signed [smpp_pkg::SCORE_BITS-1:0] i_thr,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [smpp_pkg::COORD_BITS-1:0]        o_peak_x,
    output logic [smpp_pkg::COORD_BITS-1:0]        o_peak_y,
    output logic signed [smpp_pkg::SCORE_BITS-1:0] o_peak_score,
    output logic                                   o_frame_end
);
    import smpp_pkg::*;

    logic [2*SCORE_BITS-1:0]      r_line_mem [MAX_WIDTH];
    logic [2*SCORE_BITS-1:0]      r_rd_data;
    logic signed [SCORE_BITS-1:0] r_win [9];
    t_item                        r_s1;
    t_item                        r_s2;
    logic                         r_s1_v;
    logic                         r_s2_v;
    logic                         r_ov;
    logic [COORD_BITS-1:0]        r_ox;
    logic [COORD_BITS-1:0]        r_oy;
    logic signed [SCORE_BITS-1:0] r_osc;
    logic                         r_olast;
    logic                         en;
    logic                         is_max;
    logic                         peak;
    logic signed [SCORE_BITS-1:0] top;
    logic signed [SCORE_BITS-1:0] mid;

    assign en    = !r_ov || i_ready;
    assign o_pop = en && !i_empty;
    assign top   = r_rd_data[2*SCORE_BITS-1:SCORE_BITS];
    assign mid   = r_rd_data[SCORE_BITS-1:0];

    // Both line stores share one word: upper row high, middle row low.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_line_mem[i_item.col];
        end
        if (en && r_s1_v) begin
            r_line_mem[r_s1.col] <= {mid, r_s1.score};
        end
    end

    always_comb begin
        is_max = 1'b1;
        for (int i = 0; i < 9; i++) begin
            if (r_win[i] > r_win[4]) begin
                is_max = 1'b0;
            end
        end
        peak = r_s2.test && (r_win[4] > i_thr) && is_max;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= i_item;
            r_s2 <= r_s1;
            r_ox    <= peak ? r_s2.cx : '0;
            r_oy    <= peak ? r_s2.cy : '0;
            r_osc   <= peak ? r_win[4] : '0;
            r_olast <= r_s2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_ov   <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (en) begin
            r_s1_v <= !i_empty;
            r_s2_v <= r_s1_v;
            r_ov   <= r_s2_v && (peak || r_s2.last);
            if (r_s1_v) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i*3]   <= r_win[i*3+1];
                    r_win[i*3+1] <= r_win[i*3+2];
                end
                r_win[2] <= top;
                r_win[5] <= mid;
                r_win[8] <= r_s1.score;
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_peak_x     = r_ox;
    assign o_peak_y     = r_oy;
    assign o_peak_score = r_osc;
    assign o_frame_end  = r_olast;

endmodule

/* tb/smpp_peak_checker.sv */
`timescale 1ns / 1ps

module smpp_peak_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [smpp_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [15:0]                   i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [39:0]                   i_m_tdata,
    input  logic                          i_m_tlast,
    output int                            o_waiting,
    output int                            o_mismatches,
    output int                            o_peaks,
    output int                            o_frame_ends
);
    import smpp_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0]        x;
        logic [COORD_BITS-1:0]        y;
        logic signed [SCORE_BITS-1:0] score;
        logic                         frame_end;
    } t_peak_word;

    t_peak_word expected_words[$];

    int unsigned                  frame_w;
    int unsigned                  frame_h;
    int unsigned                  band_w;
    logic signed [SCORE_BITS-1:0] threshold;

    logic signed [SCORE_BITS-1:0] row_two_up [MAX_WIDTH];
    logic signed [SCORE_BITS-1:0] row_one_up [MAX_WIDTH];
    logic signed [SCORE_BITS-1:0] win [9];
    int unsigned                  next_col;
    int unsigned                  next_row;

    int mismatch_count = 0;
    int peak_count     = 0;
    int end_count      = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        return (v < 3) ? 3 : ((v > hi) ? hi : v);
    endfunction

    function automatic logic in_band(input int unsigned c, input int unsigned r,
                                     input int unsigned w, input int unsigned h,
                                     input int unsigned b);
        return (c < b) || (c + b >= w) || (r < b) || (r + b >= h);
    endfunction

    task step_window(input logic signed [SCORE_BITS-1:0] pix);
        int unsigned                  w;
        int unsigned                  h;
        int unsigned                  b;
        int unsigned                  c;
        int unsigned                  r;
        logic signed [SCORE_BITS-1:0] v;
        logic signed [SCORE_BITS-1:0] best;
        logic                         is_peak;
        logic                         is_last;
        t_peak_word                   item;
        w = clamp_dim(frame_w, MAX_WIDTH);
        h = clamp_dim(frame_h, MAX_HEIGHT);
        b = (band_w == 0) ? 1 : band_w;
        c = next_col;
        r = next_row;
        v = in_band(c, r, w, h, b) ? '0 : pix;

        for (int i = 0; i < 3; i++) begin
            win[i * 3 + 0] = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
        end
        win[2] = row_two_up[c];
        win[5] = row_one_up[c];
        win[8] = v;
        row_two_up[c] = row_one_up[c];
        row_one_up[c] = v;

        is_peak = 1'b0;
        if (c >= 1 && r >= 1 && !in_band(c - 1, r - 1, w, h, b)) begin
            best = win[0];
            for (int i = 1; i < 9; i++) begin
                if (win[i] > best) best = win[i];
            end
            is_peak = (win[4] > threshold) && (win[4] == best);
        end

        is_last = (c + 1 >= w) && (r + 1 >= h);
        if (c + 1 >= w) begin
            next_col = 0;
            next_row = is_last ? 0 : r + 1;
        end else begin
            next_col = c + 1;
        end

        if (is_peak || is_last) begin
            item.x         = is_peak ? COORD_BITS'(c - 1) : '0;
            item.y         = is_peak ? COORD_BITS'(r - 1) : '0;
            item.score     = is_peak ? win[4] : '0;
            item.frame_end = is_last;
            expected_words = {expected_words, item};
        end
        if (is_peak) peak_count++;
        if (is_last) end_count++;
    endtask

    always @(posedge i_clk) begin
        t_peak_word got;
        t_peak_word want;
        if (!i_rst_n) begin
            frame_w   = RST_WIDTH;
            frame_h   = RST_HEIGHT;
            band_w    = RST_BORDER;
            threshold = '0;
            next_col  = 0;
            next_row  = 0;
            foreach (win[i]) win[i] = '0;
            foreach (row_two_up[i]) begin
                row_two_up[i] = '0;
                row_one_up[i] = '0;
            end
            expected_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.x         = i_m_tdata[10:0];
                got.y         = i_m_tdata[21:11];
                got.score     = i_m_tdata[37:22];
                got.frame_end = i_m_tlast;
                if (expected_words.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected result word x=%0d y=%0d score=%0d end=%0b",
                                 $time, got.x, got.y, got.score, got.frame_end);
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want || i_m_tdata[39:38] !== 2'b00) begin
                        if (mismatch_count < 10)
                            $display({"%0t: result mismatch, expected x=%0d y=%0d score=%0d ",
                                      "end=%0b, got x=%0d y=%0d score=%0d end=%0b pad=%b"},
                                     $time, want.x, want.y, want.score, want.frame_end,
                                     got.x, got.y, got.score, got.frame_end,
                                     i_m_tdata[39:38]);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FRAME_WIDTH: begin
                        frame_w  = i_cfg_data[GEO_BITS-1:0];
                        next_col = 0;
                        next_row = 0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        frame_h  = i_cfg_data[GEO_BITS-1:0];
                        next_col = 0;
                        next_row = 0;
                    end
                    CFG_BORDER_WIDTH: band_w = i_cfg_data[BORDER_BITS-1:0];
                    CFG_THRESHOLD: threshold = i_cfg_data[SCORE_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) step_window(i_s_tdata);
        end
        o_waiting    <= expected_words.size();
        o_mismatches <= mismatch_count;
        o_peaks      <= peak_count;
        o_frame_ends <= end_count;
    end

endmodule

/* tb/score_map_peak_picker_3x3_tb.sv */
`timescale 1ns / 1ps

module score_map_peak_picker_3x3_tb;
    import smpp_pkg::*;

    localparam int     CLK_PERIOD  = 10;
    localparam int     RAND_WORDS  = 1024;
    localparam int     EDGE_WORDS  = 256;
    localparam int     HOLD_CYCLES = 300;
    localparam int     SETTLE      = 8;
    localparam longint TIMEOUT_NS  = 4_000_000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_idx;
    logic [CFG_BITS-1:0] i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [39:0]         m_axis_tdata;
    logic                m_axis_tlast;

    int words_waiting;
    int fail_count;
    int peak_count;
    int end_count;

    int          send_idle_pct = 12;
    int          recv_idle_pct = 46;
    logic        hold_req      = 1'b0;
    logic        hold_done     = 1'b0;
    int unsigned n_sent        = 0;
    int unsigned n_settings    = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    score_map_peak_picker_3x3 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    smpp_peak_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .o_waiting    (words_waiting),
        .o_mismatches (fail_count),
        .o_peaks      (peak_count),
        .o_frame_ends (end_count)
    );

    function automatic int unsigned eff_dim(input logic [GEO_BITS-1:0] v);
        return (v < 3) ? 3 : ((v > 2048) ? 2048 : int'(v));
    endfunction

    task send_word(input logic [15:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_sent++;
    endtask

    task send_random(input int unsigned count);
        int unsigned pick;
        logic [15:0] word;
        for (int unsigned k = 0; k < count; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                word = 16'($urandom);
            else if (pick < 7)
                word = 16'($urandom_range(0, 6) - 3);
            else if (pick == 7)
                word = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            else
                word = 16'($urandom_range(0, 4095));
            send_word(word);
        end
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (words_waiting != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task cfg_write(input t_cfg_idx idx, input logic [CFG_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task program_regs(input logic [3:0] sel, input logic [GEO_BITS-1:0] w,
                      input logic [GEO_BITS-1:0] h, input logic [BORDER_BITS-1:0] b,
                      input logic [15:0] thr);
        if (sel[CFG_FRAME_WIDTH])  cfg_write(CFG_FRAME_WIDTH, {4'($urandom), w});
        if (sel[CFG_FRAME_HEIGHT]) cfg_write(CFG_FRAME_HEIGHT, {4'($urandom), h});
        if (sel[CFG_BORDER_WIDTH]) cfg_write(CFG_BORDER_WIDTH, {10'($urandom), b});
        if (sel[CFG_THRESHOLD])    cfg_write(CFG_THRESHOLD, thr);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        int unsigned          n_rand;
        int unsigned          n;
        int unsigned          ew;
        int unsigned          eh;
        int unsigned          pick;
        logic [GEO_BITS-1:0]  w_raw;
        logic [GEO_BITS-1:0]  h_raw;
        logic [BORDER_BITS-1:0] b_val;
        logic [15:0]          thr_val;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_FRAME_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Undersized geometry and a zero border give a 3x3 frame whose only
        // candidate is decided on the last pixel, so peak and frame end share a word.
        program_regs(4'b1111, 12'd1, 12'd2, 6'd0, 16'h7FFE);
        for (int i = 0; i < 9; i++) send_word(i == 4 ? 16'h7FFF : 16'd100);
        drain();

        // Flat interior: tied maxima must all be reported.
        program_regs(4'b1111, 12'd4, 12'd3, 6'd1, 16'hFFFF);
        repeat (12) send_word(16'd5);
        drain();

        // Long output stall while the sender keeps offering words.
        program_regs(4'b1111, 12'd8, 12'd6, 6'd1, 16'h8000);
        hold_req = 1'b1;
        send_random(4 * 8 * 6);

        n_rand = 0;
        while (n_rand < RAND_WORDS) begin
            if (n_rand < RAND_WORDS / 3) begin
                send_idle_pct = 12;
                recv_idle_pct = 46;
            end else if (n_rand < 2 * RAND_WORDS / 3) begin
                send_idle_pct = 46;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            pick = $urandom_range(0, 9);
            if (pick < 5)       b_val = 6'd1;
            else if (pick == 5) b_val = 6'd0;
            else if (pick < 8)  b_val = 6'd2;
            else if (pick == 8) b_val = 6'($urandom_range(3, 5));
            else                b_val = 6'($urandom_range(6, 63));

            pick = $urandom_range(0, 9);
            if (pick == 0)      thr_val = 16'h8000;
            else if (pick == 1) thr_val = 16'h7FFF;
            else if (pick == 2) thr_val = 16'h0000;
            else if (pick < 6)  thr_val = 16'($urandom_range(0, 6) - 3);
            else                thr_val = 16'($urandom);

            drain();
            if ($urandom_range(0, 9) < 8) begin
                pick = $urandom_range(0, 15);
                if (pick == 0)      w_raw = 12'($urandom_range(0, 2));
                else if (pick == 1) w_raw = 12'($urandom_range(16, 40));
                else                w_raw = 12'($urandom_range(3, 12));
                pick = $urandom_range(0, 15);
                if (pick == 0)      h_raw = 12'($urandom_range(0, 2));
                else if (pick == 1) h_raw = 12'($urandom_range(9, 16));
                else                h_raw = 12'($urandom_range(3, 8));
                ew = eff_dim(w_raw);
                eh = eff_dim(h_raw);
                n = (ew * eh > 100) ? ew * eh : $urandom_range(1, 2) * ew * eh;
                if ($urandom_range(0, 3) == 0) n += $urandom_range(1, ew * eh - 1);
                program_regs(4'b1111, w_raw, h_raw, b_val, thr_val);
            end else begin
                // Border and threshold change in the middle of a frame.
                n = $urandom_range(5, 40);
                program_regs(4'b1100, '0, '0, b_val, thr_val);
            end
            send_random(n);
            n_rand += n;
        end

        drain();
        program_regs(4'b1111, 12'hFFF, 12'd0, 6'($urandom_range(1, 2)),
                     16'($urandom_range(0, 6) - 3));
        send_random(EDGE_WORDS);
        drain();
        program_regs(4'b1111, 12'd3, 12'd2048, 6'd1, 16'h8000);
        send_random(EDGE_WORDS);
        drain();

        $display({"Sent %0d score words under %0d register settings, full frames from 3x3 ",
                  "up and partial 2048-wide and 2048-high frames."},
                 n_sent, n_settings);
        $display("Checked %0d peaks and %0d frame ends, including a %0d-cycle output stall.",
                 peak_count, end_count, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
